// ===== src/fbtc_pkg.sv =====
package fbtc_pkg;

  // table geometry
  localparam int DEPTH     = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ADDR_BITS = 20;
  localparam int START_W   = ADDR_BITS;
  localparam int SIZE_W    = ADDR_BITS + 1;
  localparam int SUM_W     = SIZE_W + 1;
  localparam int LVL       = $clog2(DEPTH);

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_REL  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_FULL = 2'd1;
  localparam logic [1:0] STS_IDX  = 2'd2;
  localparam logic [1:0] STS_OVF  = 2'd3;

  // per-cell update actions
  localparam int ACT_W = 3;
  typedef logic [ACT_W-1:0] act_t;
  localparam act_t ACT_HOLD  = 3'd0;
  localparam act_t ACT_LEFT  = 3'd1;
  localparam act_t ACT_RIGHT = 3'd2;
  localparam act_t ACT_NEW   = 3'd3;
  localparam act_t ACT_EXT   = 3'd4;
  localparam act_t ACT_MERGE = 3'd5;
  localparam act_t ACT_GROW  = 3'd6;

  // one table entry: start, size and end address
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic [SIZE_W-1:0]  limit;
  } entry_t;

  // block word broadcast to every cell
  typedef struct packed {
    logic [START_W-1:0] s;
    logic [SIZE_W-1:0]  len;
    logic [SIZE_W-1:0]  e;
  } cmd_t;

  // compare results held in each cell
  typedef struct packed {
    logic eq_end;
    logic gt;
    logic eq_start;
  } flags_t;

  // operation summary handed to the scan logic
  typedef struct packed {
    logic [1:0] op;
    logic       ovf;
    logic       zero_len;
  } req_t;

  // outcome of the scan
  typedef struct packed {
    logic [CNT_W-1:0] cnt_nxt;
    logic [1:0]       status;
  } res_t;

  // exclusive prefix OR, log-depth
  function automatic logic [DEPTH-1:0] pre_or(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0] x;
    x = v;
    for (int k = 0; k < LVL; k++) begin
      x = x | (x << (1 << k));
    end
    return x << 1;
  endfunction

endpackage

// ===== src/fbtc_cell.sv =====
module fbtc_cell (
  input  logic            clk,
  input  fbtc_pkg::cmd_t  cmd,
  input  logic            cmp_en,
  input  logic            valid,
  input  fbtc_pkg::act_t  act,
  input  fbtc_pkg::entry_t left,
  input  fbtc_pkg::entry_t right,
  output fbtc_pkg::entry_t ent,
  output fbtc_pkg::flags_t flg
);
  import fbtc_pkg::*;

  entry_t             ent_r, ent_nxt;
  flags_t             flg_r;
  logic [SIZE_W-1:0]  ext_sz_r;

  // compare pass: local matches against the incoming word
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      flg_r.eq_end   <= valid && (ent_r.limit == {1'b0, cmd.s});
      flg_r.gt       <= valid && (ent_r.start > cmd.s);
      flg_r.eq_start <= valid && ({1'b0, ent_r.start} == cmd.e);
      ext_sz_r       <= ent_r.size + cmd.len;
    end
  end

  // update pass: hold, shift, take the new word, extend, merge or grow downward
  always_comb begin
    ent_nxt = ent_r;
    case (act)
      ACT_LEFT:  ent_nxt = left;
      ACT_RIGHT: ent_nxt = right;
      ACT_NEW: begin
        ent_nxt.start = cmd.s;
        ent_nxt.size  = cmd.len;
        ent_nxt.limit = cmd.e;
      end
      ACT_EXT: begin
        ent_nxt.size  = ext_sz_r;
        ent_nxt.limit = cmd.e;
      end
      ACT_MERGE: begin
        ent_nxt.size  = ext_sz_r + right.size;
        ent_nxt.limit = right.limit;
      end
      ACT_GROW: begin
        ent_nxt.start = cmd.s;
        ent_nxt.size  = ext_sz_r;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
  assign flg = flg_r;

endmodule

// ===== src/fbtc_scan.sv =====
module fbtc_scan (
  input  fbtc_pkg::req_t                 req,
  input  logic                           go,
  input  logic [fbtc_pkg::CNT_W-1:0]     cnt,
  input  logic [fbtc_pkg::DEPTH-1:0]     valid_v,
  input  logic [fbtc_pkg::DEPTH-1:0]     eq_end_v,
  input  logic [fbtc_pkg::DEPTH-1:0]     gt_v,
  input  logic [fbtc_pkg::DEPTH-1:0]     eq_start_v,
  output fbtc_pkg::act_t                 act [fbtc_pkg::DEPTH],
  output fbtc_pkg::res_t                 res
);
  import fbtc_pkg::*;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_INS  = 2'd1;
  localparam logic [1:0] K_EXT  = 2'd2;
  localparam logic [1:0] K_GROW = 2'd3;

  logic [DEPTH-1:0] hit, hit_pre, first, win_a, win_b, merge_v, grow_v;
  logic [DEPTH-1:0] key, key_pre, ins_first;
  logic             any_a, any_b, any_grow, merge, full;
  logic [1:0]       kind;

  // first entry that either ends at the freed start or starts above it
  assign hit     = eq_end_v | gt_v;
  assign hit_pre = pre_or(hit);
  assign first   = hit & ~hit_pre;
  assign win_a   = first & eq_end_v;
  assign win_b   = first & ~eq_end_v;
  assign merge_v = win_a & (eq_start_v >> 1);
  assign grow_v  = win_b & eq_start_v;
  assign any_a    = |win_a;
  assign any_b    = |win_b;
  assign any_grow = |grow_v;
  assign merge    = |merge_v;

  // sorted insert position: first entry above, else first free slot
  assign key       = gt_v | ~valid_v;
  assign key_pre   = pre_or(key);
  assign ins_first = key & ~key_pre;

  assign full = (cnt == CNT_W'(DEPTH));

  // choose what this word does
  always_comb begin
    kind       = K_NONE;
    res.status = STS_OK;
    if (req.op == OP_LOAD || req.op == OP_REL) begin
      if (req.ovf) begin
        res.status = STS_OVF;
      end else if (!req.zero_len) begin
        if (req.op == OP_REL && any_a) begin
          kind = K_EXT;
        end else if (req.op == OP_REL && any_b && any_grow) begin
          kind = K_GROW;
        end else if (full) begin
          res.status = STS_FULL;
        end else begin
          kind = K_INS;
        end
      end
    end
  end

  // new count
  always_comb begin
    res.cnt_nxt = cnt;
    if (kind == K_INS) begin
      res.cnt_nxt = cnt + CNT_W'(1);
    end else if (kind == K_EXT && merge) begin
      res.cnt_nxt = cnt - CNT_W'(1);
    end
  end

  // per-cell actions
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      act[i] = ACT_HOLD;
      if (go) begin
        case (kind)
          K_INS: begin
            if (ins_first[i]) begin
              act[i] = ACT_NEW;
            end else if (key_pre[i]) begin
              act[i] = ACT_LEFT;
            end
          end
          K_EXT: begin
            if (win_a[i]) begin
              act[i] = merge ? ACT_MERGE : ACT_EXT;
            end else if (merge && hit_pre[i]) begin
              act[i] = ACT_RIGHT;
            end
          end
          K_GROW: begin
            if (grow_v[i]) begin
              act[i] = ACT_GROW;
            end
          end
          default: act[i] = ACT_HOLD;
        endcase
      end
    end
  end

endmodule

// ===== src/free_block_table_coalesce.sv =====
// An accepted word is captured, then passes through the compare pass and the
// update pass over the cell row; the result word is registered at the end of
// the update pass, and a new word can be taken during that update pass.
// The receiver cannot stall; out_valid lasts one cycle.
// Reset (synchronous, rst_n low): clears the entry count and control state;
// table contents are left undefined, with no clearing pass.
module free_block_table_coalesce (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_op,
  input  logic [fbtc_pkg::START_W-1:0]   in_block_start,
  input  logic [fbtc_pkg::SIZE_W-1:0]    in_block_length,
  input  logic [fbtc_pkg::IDX_W-1:0]     in_entry_index,
  output logic                           out_valid,
  output logic [fbtc_pkg::START_W-1:0]   out_entry_start,
  output logic [fbtc_pkg::SIZE_W-1:0]    out_entry_size,
  output logic [fbtc_pkg::CNT_W-1:0]     out_entry_count,
  output logic [1:0]                     out_status
);
  import fbtc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               accept;
  cmd_t               cmd_r;
  logic [1:0]         op_r;
  logic [IDX_W-1:0]   idx_r;
  logic               ovf_r, zero_r;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   cnt_r;

  entry_t             ents [DEPTH];
  flags_t             flgs [DEPTH];
  act_t               acts [DEPTH];
  logic [DEPTH-1:0]   valid_v, eq_end_v, gt_v, eq_start_v;
  req_t               req;
  res_t               res;

  entry_t             rd_ent;
  logic               rd_ok;

  logic               out_valid_r;
  logic [START_W-1:0] out_start_r;
  logic [SIZE_W-1:0]  out_size_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [1:0]         out_status_r;

  assign busy   = (state_r == S_CMP);
  assign accept = start && !busy;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_CMP : S_IDLE;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = accept ? S_CMP : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the input word and its end address
  assign sum = {2'b00, in_block_start} + {1'b0, in_block_length};

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.s   <= in_block_start;
      cmd_r.len <= in_block_length;
      cmd_r.e   <= sum[SIZE_W-1:0];
      op_r      <= in_op;
      idx_r     <= in_entry_index;
      ovf_r     <= (sum > (SUM_W'(1) << ADDR_BITS));
      zero_r    <= (in_block_length == '0);
    end
  end

  // occupancy thermometer
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_v[i] = (CNT_W'(i) < cnt_r);
    end
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_w, right_w;
    if (g == 0) begin : g_lo
      assign left_w = '0;
    end else begin : g_lo
      assign left_w = ents[g-1];
    end
    if (g == DEPTH - 1) begin : g_hi
      assign right_w = '0;
    end else begin : g_hi
      assign right_w = ents[g+1];
    end

    fbtc_cell u_cell (
      .clk    (clk),
      .cmd    (cmd_r),
      .cmp_en (state_r == S_CMP),
      .valid  (valid_v[g]),
      .act    (acts[g]),
      .left   (left_w),
      .right  (right_w),
      .ent    (ents[g]),
      .flg    (flgs[g])
    );

    assign eq_end_v[g]   = flgs[g].eq_end;
    assign gt_v[g]       = flgs[g].gt;
    assign eq_start_v[g] = flgs[g].eq_start;
  end

  // decision logic over the row
  assign req.op       = op_r;
  assign req.ovf      = ovf_r;
  assign req.zero_len = zero_r;

  fbtc_scan u_scan (
    .req        (req),
    .go         (state_r == S_UPD),
    .cnt        (cnt_r),
    .valid_v    (valid_v),
    .eq_end_v   (eq_end_v),
    .gt_v       (gt_v),
    .eq_start_v (eq_start_v),
    .act        (acts),
    .res        (res)
  );

  // read select, AND-OR over the row
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (IDX_W'(i) == idx_r) begin
        rd_ent = rd_ent | ents[i];
      end
    end
  end

  assign rd_ok = ({1'b0, idx_r} < cnt_r);

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == S_UPD) begin
      cnt_r <= res.cnt_nxt;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      out_cnt_r <= res.cnt_nxt;
      if (op_r == OP_READ) begin
        out_start_r  <= rd_ok ? rd_ent.start : '0;
        out_size_r   <= rd_ok ? rd_ent.size : '0;
        out_status_r <= rd_ok ? STS_OK : STS_IDX;
      end else begin
        out_start_r  <= '0;
        out_size_r   <= '0;
        out_status_r <= res.status;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_start = out_start_r;
  assign out_entry_size  = out_size_r;
  assign out_entry_count = out_cnt_r;
  assign out_status      = out_status_r;

  // every accepted word raises its result strobe after its compare and update passes
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##2 out_valid)
    else $error("result strobe missing after accepted word");

  // compare pass lasts exactly one cycle
  a_cmp_once: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("compare pass held over");

  // count never exceeds the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  // an out-of-range read returns an empty entry
  a_idx_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_IDX) |->
      (out_entry_start == '0 && out_entry_size == '0))
    else $error("out-of-range read returned data");

endmodule

// ===== tb/free_block_table_coalesce_tb.sv =====
module free_block_table_coalesce_tb;
  import fbtc_pkg::*;

  localparam int TOP           = 1 << ADDR_BITS;
  localparam int MAX_PIECE     = 4096;
  localparam int CYCLE_LIMIT   = 60000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [1:0] OP_SPARE = 2'd3;  // unused op code

  // one result word as the block should present it
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
    logic [CNT_W-1:0]   count;
    logic [1:0]         status;
  } outcome_t;

  // shapes of generated words
  typedef enum int {
    GEN_MERGE, GEN_EXTEND, GEN_GROW, GEN_INSERT, GEN_READ, GEN_NOISE
  } gen_kind_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_op;
  logic [START_W-1:0]   in_block_start;
  logic [SIZE_W-1:0]    in_block_length;
  logic [IDX_W-1:0]     in_entry_index;
  logic                 out_valid;
  logic [START_W-1:0]   out_entry_start;
  logic [SIZE_W-1:0]    out_entry_size;
  logic [CNT_W-1:0]     out_entry_count;
  logic [1:0]           out_status;

  outcome_t pending_results[$];
  int       mismatches  = 0;
  int       cycle_count = 0;

  // shadow copy of the free block table
  logic [START_W-1:0] fb_start [DEPTH];
  logic [SIZE_W-1:0]  fb_size  [DEPTH];
  logic [SIZE_W-1:0]  fb_end   [DEPTH];
  int                 fb_count;

  free_block_table_coalesce uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_block_start  (in_block_start),
    .in_block_length (in_block_length),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_entry_start (out_entry_start),
    .out_entry_size  (out_entry_size),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("free_block_table_coalesce_tb: FAIL");
      $finish;
    end
  end

  // shift entries up from pos to make room
  function automatic void open_gap(int pos);
    int k;
    for (k = fb_count; k > pos; k--) begin
      fb_start[k] = fb_start[k-1];
      fb_size[k]  = fb_size[k-1];
      fb_end[k]   = fb_end[k-1];
    end
    fb_count++;
  endfunction

  // remove the entry at pos
  function automatic void close_gap(int pos);
    int k;
    for (k = pos; k + 1 < fb_count; k++) begin
      fb_start[k] = fb_start[k+1];
      fb_size[k]  = fb_size[k+1];
      fb_end[k]   = fb_end[k+1];
    end
    fb_count--;
  endfunction

  function automatic void set_entry(int pos, logic [START_W-1:0] s,
                                    logic [SIZE_W-1:0] len, logic [SIZE_W-1:0] e);
    fb_start[pos] = s;
    fb_size[pos]  = len;
    fb_end[pos]   = e;
  endfunction

  // sorted insert, newer after older on equal start
  function automatic logic [1:0] load_block(logic [START_W-1:0] s,
                                            logic [SIZE_W-1:0] len, logic [SIZE_W-1:0] e);
    int pos;
    pos = 0;
    if (fb_count >= DEPTH) return STS_FULL;
    while (pos < fb_count && fb_start[pos] <= s) pos++;
    open_gap(pos);
    set_entry(pos, s, len, e);
    return STS_OK;
  endfunction

  // free a block, coalescing with its neighbours
  function automatic logic [1:0] release_block(logic [START_W-1:0] s,
                                               logic [SIZE_W-1:0] len, logic [SIZE_W-1:0] e);
    int i;
    for (i = 0; i < fb_count; i++) begin
      if (fb_end[i] == s) begin
        if (i + 1 < fb_count && fb_start[i+1] == e) begin
          fb_size[i] = fb_size[i] + len + fb_size[i+1];
          fb_end[i]  = fb_start[i] + fb_size[i];
          close_gap(i + 1);
        end else begin
          fb_size[i] = fb_size[i] + len;
          fb_end[i]  = fb_start[i] + fb_size[i];
        end
        return STS_OK;
      end
      if (fb_start[i] > s) begin
        // grow downward; end stays as it was
        if (fb_start[i] == e) begin
          fb_start[i] = s;
          fb_size[i]  = fb_size[i] + len;
          return STS_OK;
        end
        if (fb_count >= DEPTH) return STS_FULL;
        open_gap(i);
        set_entry(i, s, len, e);
        return STS_OK;
      end
    end
    if (fb_count >= DEPTH) return STS_FULL;
    set_entry(fb_count, s, len, e);
    fb_count++;
    return STS_OK;
  endfunction

  // apply one word to the shadow table and give the result it should cause
  function automatic outcome_t table_update(logic [1:0] op, logic [START_W-1:0] s,
                                            logic [SIZE_W-1:0] len, logic [IDX_W-1:0] idx);
    outcome_t         r;
    logic [SUM_W-1:0] e;
    r = '0;
    e = s + len;
    case (op)
      OP_LOAD, OP_REL: begin
        if (e > TOP)
          r.status = STS_OVF;
        else if (len != 0)
          r.status = (op == OP_LOAD) ? load_block(s, len, e[SIZE_W-1:0])
                                     : release_block(s, len, e[SIZE_W-1:0]);
      end
      OP_READ: begin
        if (idx < fb_count) begin
          r.start = fb_start[idx];
          r.size  = fb_size[idx];
        end else begin
          r.status = STS_IDX;
        end
      end
      default: ;
    endcase
    r.count = fb_count[CNT_W-1:0];
    return r;
  endfunction

  // free span before entry i (or after the last one)
  function automatic void gap_at(int i, output int lo, output int hi);
    lo = (i == 0) ? 0 : int'(fb_end[i-1]);
    hi = (i == fb_count) ? TOP : int'(fb_start[i]);
  endfunction

  function automatic int piece(int span);
    return (span < MAX_PIECE) ? span : MAX_PIECE;
  endfunction

  // drive one word and hold it until the block takes it
  task automatic send_word(input logic [1:0] op, input logic [START_W-1:0] s,
                           input logic [SIZE_W-1:0] len, input logic [IDX_W-1:0] idx);
    @(negedge clk);
    start           <= 1'b1;
    in_op           <= op;
    in_block_start  <= s;
    in_block_length <= len;
    in_entry_index  <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(table_update(op, s, len, idx));
  endtask

  task automatic sender_gap(input int pct);
    int n;
    if ($urandom_range(99) < pct) begin
      n = $urandom_range(6, 1);
      repeat (n) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // steer the table size towards target
  function automatic gen_kind_t pick_kind(int target);
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return GEN_READ;
    if (roll < 40) return GEN_NOISE;
    if (roll < 50) return GEN_EXTEND;
    if (roll < 60) return GEN_GROW;
    return (fb_count <= target) ? GEN_INSERT : GEN_MERGE;
  endfunction

  // build a word of the given shape from the current table
  task automatic random_word(input gen_kind_t kind);
    int               lo, hi, i, tries, s, len;
    bit               found;
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    found = 1'b0;
    lo    = 0;
    hi    = 0;
    for (tries = 0; tries < 8 && !found; tries++) begin
      i = $urandom_range(fb_count, 0);
      gap_at(i, lo, hi);
      case (kind)
        GEN_MERGE:  found = i > 0 && i < fb_count && hi > lo;
        GEN_EXTEND: found = i > 0 && hi - lo >= 2;
        GEN_GROW:   found = i < fb_count && hi - lo >= 2;
        GEN_INSERT: found = hi - lo >= 3;
        default:    found = 1'b1;
      endcase
    end
    if (!found) kind = GEN_READ;

    op  = OP_REL;
    s   = lo;
    len = hi - lo;
    idx = IDX_W'($urandom);
    case (kind)
      GEN_MERGE: ;  // fills the gap exactly, absorbing the next entry
      GEN_EXTEND: len = $urandom_range(piece(hi - lo - 1), 1);
      GEN_GROW: begin
        len = $urandom_range(piece(hi - lo - 1), 1);
        s   = hi - len;
      end
      GEN_INSERT: begin
        s   = $urandom_range(hi - 2, lo + 1);
        len = $urandom_range(piece(hi - 1 - s), 1);
        op  = $urandom_range(1) ? OP_LOAD : OP_REL;
      end
      GEN_READ: begin
        op = OP_READ;
        if (fb_count > 0 && $urandom_range(1))
          idx = IDX_W'($urandom_range(fb_count - 1, 0));
      end
      default: begin
        // mostly overflowing sizes, so stray blocks stay rare
        op  = 2'($urandom);
        s   = $urandom;
        len = $urandom & 32'h1FFFFF;
        if ((op == OP_LOAD || op == OP_REL) && $urandom_range(7) != 0)
          len = len | 32'h100000;
      end
    endcase
    send_word(op, START_W'(s), SIZE_W'(len), idx);
  endtask

  // field extremes, every op and each corner of the coalescing walk
  task automatic test_directed();
    send_word(OP_READ, '0, '0, '0);                // read on an empty table
    send_word(OP_SPARE, '1, '1, '1);               // unused op
    send_word(OP_LOAD, '0, '0, '0);                // zero length
    send_word(OP_REL, 20'h12345, '0, '0);
    send_word(OP_LOAD, 20'hFFFFF, 21'd2, '0);      // one past the top
    send_word(OP_REL, '0, 21'h1FFFFF, '0);         // largest length
    send_word(OP_LOAD, '0, 21'h10, '0);
    send_word(OP_REL, 20'h200, 21'h8, '0);         // no match: appended
    send_word(OP_LOAD, 20'hFFFFF, 21'd1, '0);      // ends exactly at the top
    send_word(OP_LOAD, 20'h40000, 21'h100, '0);
    send_word(OP_LOAD, 20'h40000, 21'h80, '0);     // equal start goes after
    send_word(OP_READ, '0, '0, 6'd2);
    send_word(OP_READ, '0, '0, 6'd3);
    send_word(OP_REL, 20'h10, 21'h10, '0);         // extend only
    send_word(OP_REL, 20'h20, 21'h1E0, '0);        // extend and absorb next
    send_word(OP_LOAD, 20'h80000, 21'h20, '0);
    send_word(OP_REL, 20'h7FFC0, 21'h40, '0);      // next block grows down
    send_word(OP_REL, 20'h90000, 21'h10, '0);      // insert in the middle
    send_word(OP_REL, 20'hFFFFE, 21'd1, '0);       // top block grows down
    send_word(OP_READ, '0, '0, '0);
    send_word(OP_READ, '0, '0, IDX_W'(fb_count - 1));
    send_word(OP_READ, '0, '0, '1);                // out of range
  endtask

  // fill the table, then hit it with inserts, a read, an extend, a grow and a merge
  task automatic test_table_full();
    while (fb_count < DEPTH) random_word(GEN_INSERT);
    repeat (4) random_word(GEN_INSERT);
    send_word(OP_READ, '0, '0, IDX_W'(DEPTH - 1));
    random_word(GEN_EXTEND);
    random_word(GEN_GROW);
    random_word(GEN_MERGE);
  endtask

  task automatic test_random(input int n, input int gap_pct);
    int k, target;
    target = DEPTH;
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0:       target = 4;
          1:       target = 24;
          default: target = DEPTH;
        endcase
      end
      sender_gap(gap_pct);
      random_word(pick_kind(target));
    end
  endtask

  // a block spanning all of memory; left for last as it can never merge away
  task automatic test_whole_space();
    send_word(OP_REL, 20'd1, 21'h100000, '0);      // overflow by one
    send_word(OP_LOAD, '0, 21'h100000, '0);
    send_word(OP_READ, '0, '0, '0);
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_entry_start !== want.start) begin
          $error("entry_start: expected %0h, actual %0h", want.start, out_entry_start);
          mismatches++;
        end
        if (out_entry_size !== want.size) begin
          $error("entry_size: expected %0h, actual %0h", want.size, out_entry_size);
          mismatches++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, out_entry_count);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_op           <= OP_LOAD;
    in_block_start  <= '0;
    in_block_length <= '0;
    in_entry_index  <= '0;
    fb_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    test_random(240, 31);
    test_random(240, 53);
    test_random(240, 0);
    test_whole_space();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("free_block_table_coalesce_tb: PASS");
    else
      $display("free_block_table_coalesce_tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
src/fbtc_pkg.sv
src/fbtc_cell.sv
src/fbtc_scan.sv
src/free_block_table_coalesce.sv
tb/free_block_table_coalesce_tb.sv
